@@ rtl/core/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, reset values and register codes for the Sobel edge block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned FW_W      = 11;
  localparam int unsigned FH_W      = 13;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned FW_RESET = 640;
  localparam int unsigned FH_RESET = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] win_t;

endpackage

@@ rtl/core/sem_pix_if.sv @@
// ----------------------------------------------------------------------------
// sem_pix_if
// Pixel input channel: valid/ready handshake with one grey pixel per item.
// ----------------------------------------------------------------------------
interface sem_pix_if;
  import sem_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

@@ rtl/core/sem_res_if.sv @@
// ----------------------------------------------------------------------------
// sem_res_if
// Result channel: valid/ready handshake with position, magnitude and flags.
// ----------------------------------------------------------------------------
interface sem_res_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  pix_t             magnitude;
  logic             last_of_run;
  logic             frame_done;

  modport source (output valid, output out_row, output out_col, output magnitude,
                  output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input out_row, input out_col, input magnitude,
                  input last_of_run, input frame_done, output ready);
endinterface

@@ rtl/core/sobel_edge_magnitude.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel edge magnitude with frame position tracking.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          contents
//  pix_i    in   valid/ready        pixel
//  res_o    out  valid/ready        out_row, out_col, magnitude, last_of_run,
//                                   frame_done
//  cfg      in   cfg_we_i, no wait  cfg_idx_i, cfg_data_i
//
//  One pixel per cycle unless the sequencer or a stalled output holds it;
//  an item passes the input and window stages, then the output register.
//  An item with two or four results holds the sequencer until all are sent.
//  Line stores are one RAM of MAX_WIDTH words; no clearing pass after reset.
//  A stalled result holds the output register; the two item stages behind it
//  keep filling until both are full.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sem_pix_if.sink                         pix_i,
  sem_res_if.source                       res_o,
  input  logic                            cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]       cfg_data_i
);
  import sem_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // last index of an effective size, value clamped to 1..lim
  function automatic int unsigned clamp_last(input int unsigned v, input int unsigned lim);
    int unsigned r;
    if (v == 0) begin
      r = 0;
    end else if (v > lim) begin
      r = lim - 1;
    end else begin
      r = v - 1;
    end
    return r;
  endfunction

  logic [CW-1:0] wlast_q;
  logic [RW-1:0] hlast_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  logic          accept;
  logic          last_col;
  logic          last_row;

  logic          s1_valid;
  logic          s2_ready;
  pix_t          top;
  pix_t          mid;
  pix_t          bot;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_lc;
  logic          s1_lr;

  assign accept   = pix_i.valid & pix_i.ready;
  assign last_col = (col_q == wlast_q);
  assign last_row = (row_q == hlast_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= CW'(clamp_last(FW_RESET, MAX_WIDTH));
      hlast_q <= RW'(clamp_last(FH_RESET, MAX_HEIGHT));
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH: begin
          wlast_q <= CW'(clamp_last(32'(cfg_data_i[FW_W-1:0]), MAX_WIDTH));
        end
        CFG_FRAME_HEIGHT: begin
          hlast_q <= RW'(clamp_last(32'(cfg_data_i[FH_W-1:0]), MAX_HEIGHT));
        end
        default: begin
        end
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .pixel_i     (pix_i.pixel),
    .col_i       (col_q),
    .row_i       (row_q),
    .last_col_i  (last_col),
    .last_row_i  (last_row),
    .out_valid_o (s1_valid),
    .out_ready_i (s2_ready),
    .top_o       (top),
    .mid_o       (mid),
    .bot_o       (bot),
    .col_o       (s1_col),
    .row_o       (s1_row),
    .last_col_o  (s1_lc),
    .last_row_o  (s1_lr)
  );

  sem_emit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s1_valid),
    .in_ready_o    (s2_ready),
    .top_i         (top),
    .mid_i         (mid),
    .bot_i         (bot),
    .col_i         (s1_col),
    .row_i         (s1_row),
    .last_col_i    (s1_lc),
    .last_row_i    (s1_lr),
    .wlast_i       (wlast_q),
    .hlast_i       (hlast_q),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .out_row_o     (res_o.out_row),
    .out_col_o     (res_o.out_col),
    .magnitude_o   (res_o.magnitude),
    .last_of_run_o (res_o.last_of_run),
    .frame_done_o  (res_o.frame_done)
  );

endmodule

@@ rtl/core/sem_ram.sv @@
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sem_front.sv @@
// ----------------------------------------------------------------------------
// sem_front
// Input register and line stores: fetches the two pixels above the incoming
// one and hands the new window column on.
// ----------------------------------------------------------------------------
module sem_front #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sem_pkg::pix_t                 pixel_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] row_i,
  input  logic                          last_col_i,
  input  logic                          last_row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sem_pkg::pix_t                 top_o,
  output sem_pkg::pix_t                 mid_o,
  output sem_pkg::pix_t                 bot_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_o,
  output logic [$clog2(MAX_HEIGHT)-1:0] row_o,
  output logic                          last_col_o,
  output logic                          last_row_o
);
  import sem_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned LW = 2 * PIX_W;

  logic          s1_valid_q;
  pix_t          s1_px_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_lc_q;
  logic          s1_lr_q;
  logic          fwd_q;
  logic [LW-1:0] fwd_data_q;

  logic          accept;
  logic          s1_adv;
  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] line_rd;
  logic [LW-1:0] line_wd;
  pix_t          a_old;
  pix_t          b_old;

  assign s1_adv     = s1_valid_q & out_ready_i;
  assign in_ready_o = ~s1_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  // line word: upper byte is the row above, lower byte the row two above
  assign line_rd = fwd_q ? fwd_data_q : ram_rdata;
  assign a_old   = line_rd[LW-1:PIX_W];
  assign b_old   = line_rd[PIX_W-1:0];
  assign line_wd = {s1_px_q, a_old};

  sem_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (line_wd),
    .re_i    (accept),
    .raddr_i (col_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (s1_col_q == col_i);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q    <= pixel_i;
      s1_col_q   <= col_i;
      s1_row_q   <= row_i;
      s1_lc_q    <= last_col_i;
      s1_lr_q    <= last_row_i;
      fwd_data_q <= line_wd;
    end
  end

  assign out_valid_o = s1_valid_q;
  assign top_o       = b_old;
  assign mid_o       = a_old;
  assign bot_o       = s1_px_q;
  assign col_o       = s1_col_q;
  assign row_o       = s1_row_q;
  assign last_col_o  = s1_lc_q;
  assign last_row_o  = s1_lr_q;

endmodule

@@ rtl/core/sem_emit.sv @@
// ----------------------------------------------------------------------------
// sem_emit
// 3x3 window, Sobel magnitude and result sequencer: expands each item into
// its zero to four results and drives the output register.
// ----------------------------------------------------------------------------
module sem_emit #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sem_pkg::pix_t                 top_i,
  input  sem_pkg::pix_t                 mid_i,
  input  sem_pkg::pix_t                 bot_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] row_i,
  input  logic                          last_col_i,
  input  logic                          last_row_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wlast_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] hlast_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sem_pkg::ROW_W-1:0]     out_row_o,
  output logic [sem_pkg::COL_W-1:0]     out_col_o,
  output sem_pkg::pix_t                 magnitude_o,
  output logic                          last_of_run_o,
  output logic                          frame_done_o
);
  import sem_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  function automatic pix_t sobel_mag(input win_t w);
    logic [9:0]  xp;
    logic [9:0]  xn;
    logic [9:0]  yp;
    logic [9:0]  yn;
    logic [9:0]  ax;
    logic [9:0]  ay;
    logic [10:0] s;
    xp = 10'(w[2]) + 10'({w[5], 1'b0}) + 10'(w[8]);
    xn = 10'(w[0]) + 10'({w[3], 1'b0}) + 10'(w[6]);
    yp = 10'(w[0]) + 10'({w[1], 1'b0}) + 10'(w[2]);
    yn = 10'(w[6]) + 10'({w[7], 1'b0}) + 10'(w[8]);
    ax = (xp >= xn) ? (xp - xn) : (xn - xp);
    ay = (yp >= yn) ? (yp - yn) : (yn - yp);
    s  = {1'b0, ax} + {1'b0, ay};
    return (s > 11'd255) ? 8'hFF : s[7:0];
  endfunction

  logic          s2_valid_q;
  win_t          win_q;
  logic [CW-1:0] s2_col_q;
  logic [RW-1:0] s2_row_q;
  logic          s2_lc_q;
  logic          s2_lr_q;
  logic [1:0]    idx_q;

  logic             out_valid_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;
  pix_t             mag_q;
  logic             last_q;
  logic             done_q;

  logic          rnz;
  logic          cnz;
  logic          two_rows;
  logic          two_cols;
  logic          has_any;
  logic          sel_i;
  logic          sel_j;
  logic          row_first;
  logic          col_first;
  logic [RW-1:0] rr;
  logic [CW-1:0] cc;
  logic [1:0]    last_idx;
  logic          s2_last;
  logic          interior;
  pix_t          mag;
  logic          emit_ok;
  logic          s2_emit;
  logic          s2_done;
  logic          take;

  always_comb begin
    rnz       = (s2_row_q != '0);
    cnz       = (s2_col_q != '0);
    two_rows  = rnz & s2_lr_q;
    two_cols  = cnz & s2_lc_q;
    has_any   = (rnz | s2_lr_q) & (cnz | s2_lc_q);
    sel_i     = two_rows ? idx_q[0] : 1'b0;
    sel_j     = two_rows ? idx_q[1] : idx_q[0];
    row_first = rnz & ~sel_i;
    col_first = cnz & ~sel_j;
    rr        = row_first ? (s2_row_q - RW'(1)) : s2_row_q;
    cc        = col_first ? (s2_col_q - CW'(1)) : s2_col_q;
    last_idx  = {two_rows & two_cols, two_rows | two_cols};
    s2_last   = (idx_q == last_idx);
    interior  = row_first & col_first & (s2_row_q >= RW'(2)) & (s2_col_q >= CW'(2));
    mag       = interior ? sobel_mag(win_q) : '0;
    emit_ok   = ~out_valid_q | out_ready_i;
    s2_emit   = s2_valid_q & has_any & emit_ok;
    s2_done   = s2_valid_q & (~has_any | (emit_ok & s2_last));
  end

  assign in_ready_o = ~s2_valid_q | s2_done;
  assign take       = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        s2_valid_q <= 1'b1;
      end else if (s2_done) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_done) begin
        idx_q <= '0;
      end else if (s2_emit) begin
        idx_q <= idx_q + 2'd1;
      end
      if (s2_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3+0] <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= top_i;
      win_q[5] <= mid_i;
      win_q[8] <= bot_i;
      s2_col_q <= col_i;
      s2_row_q <= row_i;
      s2_lc_q  <= last_col_i;
      s2_lr_q  <= last_row_i;
    end
    if (s2_emit) begin
      out_row_q <= ROW_W'(rr);
      out_col_q <= COL_W'(cc);
      mag_q     <= mag;
      last_q    <= s2_last;
      done_q    <= (rr == hlast_i) & (cc == wlast_i);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign magnitude_o   = mag_q;
  assign last_of_run_o = last_q;
  assign frame_done_o  = done_q;

endmodule
